@@ src/spq_pkg.sv @@
// types and codes shared by the sorted priority queue files
`timescale 1ns / 1ps
`default_nettype none
package spq_pkg;

  typedef enum logic [0:0] {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e        command;
    logic [31:0] key;
    logic [15:0] tag;
    logic [7:0]  pop_index;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] out_key;
    logic [15:0] out_tag;
    logic [4:0]  count;
    logic        is_empty;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic exec;
  } ctrl_t;

endpackage
`default_nettype wire

@@ src/spq_if.sv @@
// valid/ready channel interfaces for queue commands and results
`timescale 1ns / 1ps
`default_nettype none
interface spq_in_if;
  import spq_pkg::*;
  logic valid;
  logic ready;
  in_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface spq_out_if;
  import spq_pkg::*;
  logic valid;
  logic ready;
  out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ src/spq_ctrl.sv @@
// handshake controller: accepts one transaction, then holds its result
`timescale 1ns / 1ps
`default_nettype none
module spq_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire logic           out_ready_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  output spq_pkg::ctrl_t      ctrl_o
);
  import spq_pkg::*;

  typedef enum logic [0:0] {
    S_IDLE = 1'b0,
    S_HOLD = 1'b1
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_valid_q;
  logic   exec;

  assign exec        = in_valid_i & in_ready_q;
  assign ctrl_o.exec = exec;
  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (exec) begin
            state_q     <= S_HOLD;
            in_ready_q  <= 1'b0;
            out_valid_q <= 1'b1;
          end
        end
        S_HOLD: begin
          if (out_ready_i) begin
            state_q     <= S_IDLE;
            in_ready_q  <= 1'b1;
            out_valid_q <= 1'b0;
          end
        end
        default: begin
          state_q     <= S_IDLE;
          in_ready_q  <= 1'b1;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ src/spq_datapath.sv @@
// sorted register array with per-cell compare and shift, plus result register
`timescale 1ns / 1ps
`default_nettype none
module spq_datapath #(
  parameter int DEPTH = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire spq_pkg::ctrl_t ctrl_i,
  input  wire spq_pkg::in_t   item_i,
  output spq_pkg::out_t       result_o
);
  import spq_pkg::*;

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int IW   = $clog2(DEPTH);
  localparam int CMPW = (CW > 8) ? CW : 8;

  logic [31:0]   key_q [DEPTH];
  logic [15:0]   tag_q [DEPTH];
  logic [CW-1:0] fill_q, fill_d;
  out_t          res_q, res_d;

  logic [DEPTH-1:0] le;
  logic [DEPTH-1:0] keep;
  logic             front;
  logic             full;
  logic             in_range;
  logic             do_push;
  logic             do_pop;
  logic [IW-1:0]    idx;

  assign full     = (fill_q == CW'(DEPTH));
  assign front    = (fill_q == '0) || (item_i.key <= key_q[0]);
  assign in_range = CMPW'(item_i.pop_index) < CMPW'(fill_q);
  assign idx      = item_i.pop_index[IW-1:0];
  assign do_push  = ctrl_i.exec && (item_i.command == CMD_PUSH) && !full;
  assign do_pop   = ctrl_i.exec && (item_i.command == CMD_POP) && in_range;

  // occupied entries not above the new key form a prefix of the array
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      le[i]   = (CW'(i) < fill_q) && (key_q[i] <= item_i.key);
      keep[i] = !front && le[i];
    end
  end

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic take_new;
      if (g == 0) begin : g_first
        assign take_new = !keep[0];
      end else begin : g_rest
        assign take_new = !keep[g] && keep[g-1];
      end

      always_ff @(posedge clk_i) begin
        if (do_push && !keep[g]) begin
          if (take_new) begin
            key_q[g] <= item_i.key;
            tag_q[g] <= item_i.tag;
          end else begin
            if (g > 0) begin
              key_q[g] <= key_q[(g > 0) ? g - 1 : 0];
              tag_q[g] <= tag_q[(g > 0) ? g - 1 : 0];
            end
          end
        end else if (do_pop && (g < DEPTH - 1) && (CMPW'(g) >= CMPW'(item_i.pop_index))) begin
          key_q[g] <= key_q[(g < DEPTH - 1) ? g + 1 : g];
          tag_q[g] <= tag_q[(g < DEPTH - 1) ? g + 1 : g];
        end
      end
    end
  endgenerate

  always_comb begin
    fill_d           = fill_q;
    res_d.status     = ST_OK;
    res_d.out_key    = '0;
    res_d.out_tag    = '0;
    if (item_i.command == CMD_PUSH) begin
      if (full) begin
        res_d.status = ST_FULL;
      end else begin
        fill_d = fill_q + CW'(1);
      end
    end else begin
      if (in_range) begin
        fill_d        = fill_q - CW'(1);
        res_d.out_key = key_q[idx];
        res_d.out_tag = tag_q[idx];
      end else begin
        res_d.status = ST_RANGE;
      end
    end
    res_d.count    = 5'(fill_d);
    res_d.is_empty = (fill_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (ctrl_i.exec) begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec) begin
      res_q <= res_d;
    end
  end

  assign result_o = res_q;

endmodule
`default_nettype wire

@@ src/sorted_priority_queue.sv @@
// sorted priority queue top level: controller plus sorted register array
// result: registered, and valid in the cycle after the command transaction
// commands: the next command is taken only once the result transaction completes,
//   since each update uses the whole array
// reset: fill count cleared and the queue empty; entry contents are not cleared
`timescale 1ns / 1ps
`default_nettype none
module sorted_priority_queue #(
  parameter int DEPTH = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  spq_in_if.sink    in_i,
  spq_out_if.source out_o
);
  import spq_pkg::*;

  ctrl_t ctrl;
  out_t  result;

  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .out_ready_i (out_o.ready),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .ctrl_o      (ctrl)
  );

  spq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .item_i   (in_i.data),
    .result_o (result)
  );

  assign out_o.data = result;

endmodule
`default_nettype wire

@@ tb/sv/sorted_priority_queue_test.sv @@
// self-checking testbench for the sorted priority queue: directed table, then random commands
`timescale 1ns / 1ps
module sorted_priority_queue_test;
  import spq_pkg::*;

  localparam int DEPTH = 16;
  localparam int RANDOM_ITEMS = 950;
  localparam int PLAN_LEN = 20;
  localparam int IDLE_PCT = 22;
  localparam int HOLD_CYCLES = 250;

  typedef struct {
    int unsigned reps;
    in_t         cmd;
    bit          typed;
    out_t        want;
  } step_t;

  logic clk_i;
  logic rst_ni;

  spq_in_if  in_ch ();
  spq_out_if out_ch ();

  sorted_priority_queue #(.DEPTH(DEPTH)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  // local copy of the sorted store
  logic [31:0] stored_key [DEPTH];
  logic [15:0] stored_tag [DEPTH];
  int          stored_fill;

  out_t pending_results [$];
  int   items_sent;
  int   err_count;
  int   results_checked;
  int   pushes_taken, pops_taken, full_refusals, range_refusals, peak_fill;

  // typed rows: empty pops, extremes, equal keys, full store, past-the-end pops
  step_t plan [PLAN_LEN] = '{
    '{1,  '{CMD_POP,  32'h0000_0000, 16'h0000, 8'd0},   1'b1, '{ST_RANGE, 32'h0, 16'h0, 5'd0, 1'b1}},
    '{1,  '{CMD_POP,  32'h0000_0000, 16'h0000, 8'd255}, 1'b1, '{ST_RANGE, 32'h0, 16'h0, 5'd0, 1'b1}},
    '{1,  '{CMD_PUSH, 32'hFFFF_FFFF, 16'hFFFF, 8'd0},   1'b1, '{ST_OK, 32'h0, 16'h0, 5'd1, 1'b0}},
    '{1,  '{CMD_PUSH, 32'h0000_0000, 16'h0000, 8'd0},   1'b1, '{ST_OK, 32'h0, 16'h0, 5'd2, 1'b0}},
    '{1,  '{CMD_PUSH, 32'h0000_0000, 16'h0001, 8'd0},   1'b1, '{ST_OK, 32'h0, 16'h0, 5'd3, 1'b0}},
    '{1,  '{CMD_PUSH, 32'h0001_0000, 16'h0002, 8'd0},   1'b1, '{ST_OK, 32'h0, 16'h0, 5'd4, 1'b0}},
    '{1,  '{CMD_PUSH, 32'h0001_0000, 16'h0003, 8'd0},   1'b1, '{ST_OK, 32'h0, 16'h0, 5'd5, 1'b0}},
    '{1,  '{CMD_PUSH, 32'hFFFF_FFFF, 16'h0004, 8'd0},   1'b1, '{ST_OK, 32'h0, 16'h0, 5'd6, 1'b0}},
    '{1,  '{CMD_POP,  32'h0000_0000, 16'h0000, 8'd255}, 1'b1, '{ST_RANGE, 32'h0, 16'h0, 5'd6, 1'b0}},
    '{1,  '{CMD_POP,  32'h0000_0000, 16'h0000, 8'd6},   1'b1, '{ST_RANGE, 32'h0, 16'h0, 5'd6, 1'b0}},
    '{1,  '{CMD_POP,  32'h0000_0000, 16'h0000, 8'd5},   1'b0, '0},
    '{1,  '{CMD_POP,  32'h0000_0000, 16'h0000, 8'd0},   1'b0, '0},
    '{1,  '{CMD_POP,  32'h0000_0000, 16'h0000, 8'd1},   1'b0, '0},
    '{13, '{CMD_PUSH, 32'h7FFF_8000, 16'h5555, 8'd0},   1'b0, '0},
    '{1,  '{CMD_PUSH, 32'h1234_5678, 16'hAAAA, 8'd0},   1'b1, '{ST_FULL, 32'h0, 16'h0, 5'd16, 1'b0}},
    '{1,  '{CMD_POP,  32'h0000_0000, 16'h0000, 8'd16},  1'b1, '{ST_RANGE, 32'h0, 16'h0, 5'd16, 1'b0}},
    '{1,  '{CMD_POP,  32'h0000_0000, 16'h0000, 8'd15},  1'b0, '0},
    '{1,  '{CMD_POP,  32'h0000_0000, 16'h0000, 8'd0},   1'b0, '0},
    '{14, '{CMD_POP,  32'h0000_0000, 16'h0000, 8'd0},   1'b0, '0},
    '{1,  '{CMD_POP,  32'h0000_0000, 16'h0000, 8'd0},   1'b1, '{ST_RANGE, 32'h0, 16'h0, 5'd0, 1'b1}}
  };

  // next state of the sorted store and the result one command gives
  function automatic out_t sorted_store_update(in_t c);
    out_t r;
    int   slot;
    int   i;
    r = '0;
    r.status = ST_OK;
    if (c.command == CMD_PUSH) begin
      if (stored_fill >= DEPTH) begin
        r.status = ST_FULL;
        full_refusals++;
      end else begin
        slot = 0;
        // equal to the front key goes in front, otherwise behind all equal keys
        if (stored_fill != 0 && c.key > stored_key[0]) begin
          while (slot < stored_fill && stored_key[slot] <= c.key) slot++;
        end
        for (i = stored_fill; i > slot; i--) begin
          stored_key[i] = stored_key[i - 1];
          stored_tag[i] = stored_tag[i - 1];
        end
        stored_key[slot] = c.key;
        stored_tag[slot] = c.tag;
        stored_fill++;
        pushes_taken++;
        if (stored_fill > peak_fill) peak_fill = stored_fill;
      end
    end else if (int'(c.pop_index) >= stored_fill) begin
      r.status = ST_RANGE;
      range_refusals++;
    end else begin
      slot = int'(c.pop_index);
      r.out_key = stored_key[slot];
      r.out_tag = stored_tag[slot];
      for (i = slot; i + 1 < stored_fill; i++) begin
        stored_key[i] = stored_key[i + 1];
        stored_tag[i] = stored_tag[i + 1];
      end
      stored_fill--;
      pops_taken++;
    end
    r.count = 5'(stored_fill);
    r.is_empty = (stored_fill == 0);
    return r;
  endfunction

  function automatic bit calm_stretch();
    return items_sent >= 300 && items_sent < 450;
  endfunction

  function automatic in_t random_command(int push_pct);
    in_t c;
    c.command = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
    case ($urandom_range(0, 9))
      0: c.key = 32'h0000_0000;
      1: c.key = 32'hFFFF_FFFF;
      2, 3, 4, 5: c.key = {13'd0, 3'($urandom_range(0, 7)), 16'h0000};
      6: c.key = (stored_fill > 0) ? stored_key[$urandom_range(0, stored_fill - 1)] : $urandom;
      default: c.key = $urandom;
    endcase
    c.tag = 16'($urandom);
    if (stored_fill > 0 && $urandom_range(0, 9) < 8) begin
      c.pop_index = 8'($urandom_range(0, stored_fill - 1));
    end else begin
      c.pop_index = 8'($urandom_range(0, 255));
    end
    return c;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    if (err_count < 100) begin
      $display("result %0d: %s is %0h, expected %0h", results_checked, field, got, want);
    end
    err_count++;
  endtask

  // offer one command and record its expected result once the transaction happens
  task automatic issue(in_t c, bit typed, out_t want);
    out_t predicted;
    while (!calm_stretch() && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= c;
    do @(posedge clk_i); while (!in_ch.ready);
    predicted = sorted_store_update(c);
    pending_results.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // result checker
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, key", out_ch.data.out_key, 32'h0);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.data.status !== want.status)
          report_mismatch("status", 32'(out_ch.data.status), 32'(want.status));
        if (out_ch.data.out_key !== want.out_key)
          report_mismatch("out_key", out_ch.data.out_key, want.out_key);
        if (out_ch.data.out_tag !== want.out_tag)
          report_mismatch("out_tag", 32'(out_ch.data.out_tag), 32'(want.out_tag));
        if (out_ch.data.count !== want.count)
          report_mismatch("count", 32'(out_ch.data.count), 32'(want.count));
        if (out_ch.data.is_empty !== want.is_empty)
          report_mismatch("is_empty", 32'(out_ch.data.is_empty), 32'(want.is_empty));
      end
      results_checked++;
    end
  end

  // result side: random stalls, a calm stretch, and one long hold-off
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!hold_done && items_sent >= 600) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (!rst_ni) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm_stretch() || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    int row;
    int rep;
    int n;
    int push_pct;
    stored_fill = 0;
    items_sent = 0;
    err_count = 0;
    results_checked = 0;
    pushes_taken = 0;
    pops_taken = 0;
    full_refusals = 0;
    range_refusals = 0;
    peak_fill = 0;
    push_pct = 50;
    rst_ni <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (row = 0; row < PLAN_LEN; row++) begin
      for (rep = 0; rep < int'(plan[row].reps); rep++) begin
        issue(plan[row].cmd, plan[row].typed, plan[row].want);
      end
    end

    // phases of push-heavy, balanced and pop-heavy traffic to reach full and empty
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(0, 2))
          0: push_pct = 25;
          1: push_pct = 50;
          default: push_pct = 80;
        endcase
      end
      issue(random_command(push_pct), 1'b0, '0);
    end
    in_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("commands %0d: %0d pushes stored, %0d pops returned, %0d full refusals,",
             items_sent, pushes_taken, pops_taken, full_refusals);
    $display("%0d out-of-range pops, peak fill %0d of %0d, %0d results checked",
             range_refusals, peak_fill, DEPTH, results_checked);
    if (err_count == 0) begin
      $display("[sorted_priority_queue] OK");
    end else begin
      $display("[sorted_priority_queue] ERROR");
    end
    $finish;
  end

  initial begin
    #(300_000 * 12);
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("[sorted_priority_queue] ERROR");
    $finish;
  end

endmodule
